// File: rtl/core/ps2hbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hbt_pkg
// Shared types and constants of the PS/2 host byte transceiver core.
// ----------------------------------------------------------------------------
package ps2hbt_pkg;

	// frame and counter widths
	localparam int FRAME_BITS = 8;
	localparam int TICK_W     = 10;
	localparam int BCNT_W     = 4;
	localparam int MODE_W     = 2;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	// command codes
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_INHIBIT   = 2'd0;
	localparam logic [1:0] REG_REQUEST   = 2'd1;
	localparam logic [1:0] REG_STOP_DLY  = 2'd2;
	localparam logic [1:0] REG_READ_HOLD = 2'd3;

	// register reset values
	localparam logic [TICK_W-1:0] INHIBIT_RST   = 10'd300;
	localparam logic [TICK_W-1:0] REQUEST_RST   = 10'd10;
	localparam logic [TICK_W-1:0] STOP_DLY_RST  = 10'd50;
	localparam logic [TICK_W-1:0] READ_HOLD_RST = 10'd100;

	// configuration register set
	typedef struct packed {
		logic [TICK_W-1:0] inhibit_ticks;
		logic [TICK_W-1:0] request_ticks;
		logic [TICK_W-1:0] stop_delay_ticks;
		logic [TICK_W-1:0] read_hold_ticks;
	} cfg_regs_t;

	// one tick request
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [7:0]        tx_byte;
		logic              clk_line;
		logic              data_line;
	} item_t;

	// one tick result
	typedef struct packed {
		logic       clk_drive_low;
		logic       data_drive_low;
		logic       busy_res;
		logic       write_done;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} res_t;

endpackage

// File: rtl/core/ps2hbt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hbt_cmd_if / ps2hbt_status_if
// Valid/ready channels carrying tick requests and tick results.
// ----------------------------------------------------------------------------
interface ps2hbt_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] tx_byte;
	logic       clk_line;
	logic       data_line;

	modport source (output valid, mode, tx_byte, clk_line, data_line, input ready);
	modport sink   (input valid, mode, tx_byte, clk_line, data_line, output ready);
endinterface

interface ps2hbt_status_if;
	logic       valid;
	logic       ready;
	logic       clk_drive_low;
	logic       data_drive_low;
	logic       busy_res;
	logic       write_done;
	logic       rx_valid;
	logic [7:0] rx_byte;

	modport source (output valid, clk_drive_low, data_drive_low, busy_res, write_done,
		rx_valid, rx_byte, input ready);
	modport sink   (input valid, clk_drive_low, data_drive_low, busy_res, write_done,
		rx_valid, rx_byte, output ready);
endinterface

// File: rtl/core/ps2hbt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hbt_cfg
// APB register file holding the four tick counts of the transceiver.
// ----------------------------------------------------------------------------
module ps2hbt_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ps2hbt_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ps2hbt_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ps2hbt_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                pready,
	output ps2hbt_pkg::cfg_regs_t               cfg
);

	ps2hbt_pkg::cfg_regs_t cfg_q;
	logic                  wr_en;
	logic [1:0]            reg_idx;
	logic [ps2hbt_pkg::TICK_W-1:0] rd_val;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inhibit_ticks    <= ps2hbt_pkg::INHIBIT_RST;
			cfg_q.request_ticks    <= ps2hbt_pkg::REQUEST_RST;
			cfg_q.stop_delay_ticks <= ps2hbt_pkg::STOP_DLY_RST;
			cfg_q.read_hold_ticks  <= ps2hbt_pkg::READ_HOLD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				ps2hbt_pkg::REG_INHIBIT:   cfg_q.inhibit_ticks    <= pwdata[ps2hbt_pkg::TICK_W-1:0];
				ps2hbt_pkg::REG_REQUEST:   cfg_q.request_ticks    <= pwdata[ps2hbt_pkg::TICK_W-1:0];
				ps2hbt_pkg::REG_STOP_DLY:  cfg_q.stop_delay_ticks <= pwdata[ps2hbt_pkg::TICK_W-1:0];
				ps2hbt_pkg::REG_READ_HOLD: cfg_q.read_hold_ticks  <= pwdata[ps2hbt_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			ps2hbt_pkg::REG_INHIBIT:   rd_val = cfg_q.inhibit_ticks;
			ps2hbt_pkg::REG_REQUEST:   rd_val = cfg_q.request_ticks;
			ps2hbt_pkg::REG_STOP_DLY:  rd_val = cfg_q.stop_delay_ticks;
			ps2hbt_pkg::REG_READ_HOLD: rd_val = cfg_q.read_hold_ticks;
			default:                   rd_val = '0;
		endcase
	end

	assign prdata = {{(ps2hbt_pkg::APB_DATA_W-ps2hbt_pkg::TICK_W){1'b0}}, rd_val};
	assign cfg    = cfg_q;

endmodule

// File: rtl/core/ps2hbt_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hbt_fsm
// Protocol sequencer: advances the write/read frame by one tick per step.
// ----------------------------------------------------------------------------
module ps2hbt_fsm #(
	parameter int FRAME_BITS = ps2hbt_pkg::FRAME_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  ps2hbt_pkg::item_t     item,
	input  ps2hbt_pkg::cfg_regs_t cfg,
	output ps2hbt_pkg::res_t      res
);

	// phase codes
	localparam logic [4:0] PH_IDLE    = 5'd0;
	localparam logic [4:0] PH_W_REL   = 5'd1;
	localparam logic [4:0] PH_W_INH   = 5'd2;
	localparam logic [4:0] PH_W_REQ   = 5'd3;
	localparam logic [4:0] PH_W_START = 5'd4;
	localparam logic [4:0] PH_W_BHI   = 5'd5;
	localparam logic [4:0] PH_W_BLO   = 5'd6;
	localparam logic [4:0] PH_W_PHI   = 5'd7;
	localparam logic [4:0] PH_W_PLO   = 5'd8;
	localparam logic [4:0] PH_W_SDLY  = 5'd9;
	localparam logic [4:0] PH_W_SLO   = 5'd10;
	localparam logic [4:0] PH_W_LINES = 5'd11;
	localparam logic [4:0] PH_R_FALL  = 5'd12;
	localparam logic [4:0] PH_R_START = 5'd13;
	localparam logic [4:0] PH_R_BLO   = 5'd14;
	localparam logic [4:0] PH_R_BHI   = 5'd15;
	localparam logic [4:0] PH_R_PLO   = 5'd16;
	localparam logic [4:0] PH_R_PHI   = 5'd17;
	localparam logic [4:0] PH_R_SLO   = 5'd18;
	localparam logic [4:0] PH_R_SHI   = 5'd19;
	localparam logic [4:0] PH_R_HOLD  = 5'd20;

	localparam logic [ps2hbt_pkg::BCNT_W-1:0] LAST_BIT =
		ps2hbt_pkg::BCNT_W'(FRAME_BITS);

	logic [4:0]                        phase_q,  phase_d;
	logic [ps2hbt_pkg::BCNT_W-1:0]     bcnt_q,   bcnt_d;
	logic [7:0]                        shift_q,  shift_d;
	logic                              par_q,    par_d;
	logic [ps2hbt_pkg::TICK_W-1:0]     dly_q,    dly_d;
	logic                              clk_lo_q, clk_lo_d;
	logic                              dat_lo_q, dat_lo_d;
	logic [7:0]                        rx_q,     rx_d;
	logic                              wdone, rvalid;
	logic                              dly_end;
	logic [ps2hbt_pkg::BCNT_W-1:0]     bcnt_inc;
	logic [7:0]                        shift_dn;
	logic                              par_nx;
	logic                              clk_hi, dat_hi;

	assign clk_hi   = item.clk_line;
	assign dat_hi   = item.data_line;
	assign dly_end  = (dly_q == '0);
	assign bcnt_inc = bcnt_q + 1'b1;
	assign shift_dn = {1'b0, shift_q[7:1]};
	assign par_nx   = par_q ^ shift_q[0];

	// next-state logic for one tick
	always_comb begin
		phase_d  = phase_q;
		bcnt_d   = bcnt_q;
		shift_d  = shift_q;
		par_d    = par_q;
		dly_d    = dly_q;
		clk_lo_d = clk_lo_q;
		dat_lo_d = dat_lo_q;
		rx_d     = rx_q;
		wdone    = 1'b0;
		rvalid   = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (item.mode == ps2hbt_pkg::MODE_WRITE) begin
					clk_lo_d = 1'b0;
					dat_lo_d = 1'b0;
					shift_d  = item.tx_byte;
					par_d    = 1'b1;
					bcnt_d   = '0;
					dly_d    = cfg.inhibit_ticks;
					phase_d  = PH_W_REL;
				end else if (item.mode == ps2hbt_pkg::MODE_READ) begin
					clk_lo_d = 1'b0;
					dat_lo_d = 1'b0;
					shift_d  = '0;
					bcnt_d   = '0;
					phase_d  = PH_R_FALL;
				end
			end
			PH_W_REL: begin
				if (dly_end) begin
					clk_lo_d = 1'b1;
					dly_d    = cfg.inhibit_ticks;
					phase_d  = PH_W_INH;
				end else dly_d = dly_q - 1'b1;
			end
			PH_W_INH: begin
				if (dly_end) begin
					dat_lo_d = 1'b1;
					dly_d    = cfg.request_ticks;
					phase_d  = PH_W_REQ;
				end else dly_d = dly_q - 1'b1;
			end
			PH_W_REQ: begin
				if (dly_end) begin
					clk_lo_d = 1'b0;
					phase_d  = PH_W_START;
				end else dly_d = dly_q - 1'b1;
			end
			PH_W_START: begin
				if (!clk_hi) begin
					dat_lo_d = ~shift_q[0];
					phase_d  = PH_W_BHI;
				end
			end
			PH_W_BHI: begin
				if (clk_hi) phase_d = PH_W_BLO;
			end
			// shift out the next data bit, or the parity after the last one
			PH_W_BLO: begin
				if (!clk_hi) begin
					par_d   = par_nx;
					shift_d = shift_dn;
					bcnt_d  = bcnt_inc;
					if (bcnt_inc >= LAST_BIT) begin
						dat_lo_d = ~par_nx;
						phase_d  = PH_W_PHI;
					end else begin
						dat_lo_d = ~shift_dn[0];
						phase_d  = PH_W_BHI;
					end
				end
			end
			PH_W_PHI: begin
				if (clk_hi) phase_d = PH_W_PLO;
			end
			PH_W_PLO: begin
				if (!clk_hi) begin
					dat_lo_d = 1'b0;
					dly_d    = cfg.stop_delay_ticks;
					phase_d  = PH_W_SDLY;
				end
			end
			PH_W_SDLY: begin
				if (dly_end) phase_d = PH_W_SLO;
				else dly_d = dly_q - 1'b1;
			end
			PH_W_SLO: begin
				if (!clk_hi) phase_d = PH_W_LINES;
			end
			PH_W_LINES: begin
				if (clk_hi && dat_hi) begin
					clk_lo_d = 1'b1;
					wdone    = 1'b1;
					phase_d  = PH_IDLE;
				end
			end
			PH_R_FALL: begin
				if (!clk_hi) phase_d = PH_R_START;
			end
			PH_R_START: begin
				if (clk_hi) phase_d = PH_R_BLO;
			end
			// sample a data bit on the falling clock
			PH_R_BLO: begin
				if (!clk_hi) begin
					if (dat_hi) shift_d[bcnt_q[2:0]] = 1'b1;
					phase_d = PH_R_BHI;
				end
			end
			PH_R_BHI: begin
				if (clk_hi) begin
					bcnt_d  = bcnt_inc;
					phase_d = (bcnt_inc >= LAST_BIT) ? PH_R_PLO : PH_R_BLO;
				end
			end
			PH_R_PLO: begin
				if (!clk_hi) phase_d = PH_R_PHI;
			end
			PH_R_PHI: begin
				if (clk_hi) phase_d = PH_R_SLO;
			end
			PH_R_SLO: begin
				if (!clk_hi) phase_d = PH_R_SHI;
			end
			PH_R_SHI: begin
				if (clk_hi) begin
					clk_lo_d = 1'b1;
					dly_d    = cfg.read_hold_ticks;
					phase_d  = PH_R_HOLD;
				end
			end
			PH_R_HOLD: begin
				if (dly_end) begin
					rx_d    = shift_q;
					rvalid  = 1'b1;
					phase_d = PH_IDLE;
				end else dly_d = dly_q - 1'b1;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bcnt_q   <= '0;
			shift_q  <= '0;
			par_q    <= 1'b1;
			dly_q    <= '0;
			clk_lo_q <= 1'b0;
			dat_lo_q <= 1'b0;
			rx_q     <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			bcnt_q   <= bcnt_d;
			shift_q  <= shift_d;
			par_q    <= par_d;
			dly_q    <= dly_d;
			clk_lo_q <= clk_lo_d;
			dat_lo_q <= dat_lo_d;
			rx_q     <= rx_d;
		end
	end

	// result of this tick, after the update
	assign res.clk_drive_low  = clk_lo_d;
	assign res.data_drive_low = dat_lo_d;
	assign res.busy_res       = (phase_d != PH_IDLE);
	assign res.write_done     = wdone;
	assign res.rx_valid       = rvalid;
	assign res.rx_byte        = rx_d;

endmodule

// File: rtl/core/ps2_host_byte_transceiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_host_byte_transceiver_core
// PS/2 host controller stepped by one tick request per item.
// ----------------------------------------------------------------------------
//  port      dir   handshake          payload
//  cmd       in    valid / ready      mode, tx_byte, clk_line, data_line
//  status    out   valid / ready      line drivers, busy, done pulses, rx_byte
//  apb       in    psel / penable     tick count registers 0x0 .. 0xC
//
//  one tick request per cycle while the result is not stalled; a request
//  passes the input register, then the sequencer step into the result register
//  arst_n resets the sequencer, the stage valids and the tick count registers
//  a stalled result holds its register; the input stage keeps taking
//  requests while the result register drains in the same cycle
// ----------------------------------------------------------------------------
module ps2_host_byte_transceiver_core #(
	parameter int FRAME_BITS = ps2hbt_pkg::FRAME_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ps2hbt_cmd_if.sink                        cmd,
	ps2hbt_status_if.source                   status,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ps2hbt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ps2hbt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ps2hbt_pkg::APB_DATA_W-1:0] prdata,
	output logic                              pready
);

	ps2hbt_pkg::cfg_regs_t cfg;
	ps2hbt_pkg::item_t     item_s1;
	ps2hbt_pkg::res_t      res_nx;
	ps2hbt_pkg::res_t      res_q;
	logic                  vld_s1;
	logic                  res_vld_q;
	logic                  advance;

	// register file
	ps2hbt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage handshake
	assign advance   = vld_s1 & (~res_vld_q | status.ready);
	assign cmd.ready = ~vld_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (cmd.ready) vld_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.mode      <= cmd.mode;
			item_s1.tx_byte   <= cmd.tx_byte;
			item_s1.clk_line  <= cmd.clk_line;
			item_s1.data_line <= cmd.data_line;
		end
	end

	// sequencer
	ps2hbt_fsm #(
		.FRAME_BITS (FRAME_BITS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_nx)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_vld_q <= 1'b0;
		else if (advance) res_vld_q <= 1'b1;
		else if (status.ready) res_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res_nx;
	end

	assign status.valid          = res_vld_q;
	assign status.clk_drive_low  = res_q.clk_drive_low;
	assign status.data_drive_low = res_q.data_drive_low;
	assign status.busy_res       = res_q.busy_res;
	assign status.write_done     = res_q.write_done;
	assign status.rx_valid       = res_q.rx_valid;
	assign status.rx_byte        = res_q.rx_byte;

endmodule

// File: sim/ps2_host_byte_transceiver_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_host_byte_transceiver_core_tb
// Self-checking bench for the PS/2 host byte transceiver core. Tick requests
// are shaped by a device model that clocks the bus whenever the host waits on
// an edge, and every status result is compared field by field with a local
// model of the host sequencer. Delay registers go through reset values, zero
// and random small values, written over APB while the core is drained.
// ----------------------------------------------------------------------------
module ps2_host_byte_transceiver_core_tb;
	import ps2hbt_pkg::*;

	localparam int               CYCLE_LIMIT = 400000;
	localparam int               LONG_HOLD   = 60;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	// host sequencer phases, as tracked by the bench
	typedef enum logic [4:0] {
		S_IDLE, S_WR_RELEASE, S_WR_INHIBIT, S_WR_RTS, S_WR_START,
		S_WR_BIT_HI, S_WR_BIT_LO, S_WR_PAR_HI, S_WR_PAR_LO,
		S_WR_STOP_DLY, S_WR_STOP_LO, S_WR_LINES_UP,
		S_RD_FALL, S_RD_START, S_RD_BIT_LO, S_RD_BIT_HI,
		S_RD_PAR_LO, S_RD_PAR_HI, S_RD_STOP_LO, S_RD_STOP_HI, S_RD_HOLD
	} host_phase_t;

	typedef struct {
		host_phase_t       ph;
		logic [BCNT_W-1:0] nbits;
		logic [7:0]        shift;
		logic              parity;
		logic [TICK_W-1:0] wait_cnt;
		logic              clk_low;
		logic              dat_low;
		logic [7:0]        rx_last;
	} host_state_t;

	typedef struct {
		item_t it;
		bit    wait_drain;
	} tick_req_t;

	logic clk;
	logic arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	ps2hbt_cmd_if    cmd_ch ();
	ps2hbt_status_if sts_ch ();

	ps2_host_byte_transceiver_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.status  (sts_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// stimulus side: device model state and request queue
	tick_req_t   tick_queue[$];
	host_state_t gen_host;
	cfg_regs_t   gen_cfg;
	logic        dev_clk;
	int          dev_half;
	logic [7:0]  dev_byte;
	int          gen_count;
	bit          last_leg;

	// checking side: predicted host and the results still owed
	host_state_t chk_host;
	cfg_regs_t   chk_cfg;
	res_t        want_status[$];
	res_t        got_want;
	item_t       took_item;
	int          n_err;
	int          n_taken;
	int          cycles;
	bit          cmd_taken;

	// driver and receiver state
	tick_req_t cur;
	bit        have_cur;
	int        send_gap;
	int        stall_left;
	int        hold_left;
	bit        long_hold_done;
	logic      rdy;

	// ------------------------------------------------------------------------
	// host model
	// ------------------------------------------------------------------------

	function automatic host_state_t host_reset_state();
		host_state_t s;
		s.ph       = S_IDLE;
		s.nbits    = '0;
		s.shift    = '0;
		s.parity   = 1'b1;
		s.wait_cnt = '0;
		s.clk_low  = 1'b0;
		s.dat_low  = 1'b0;
		s.rx_last  = '0;
		return s;
	endfunction

	// true once the running delay has expired, else counts it down
	function automatic logic delay_over(inout logic [TICK_W-1:0] d);
		if (d == '0)
			return 1'b1;
		d = d - 1'b1;
		return 1'b0;
	endfunction

	// one tick of the host sequencer, returns the status after the update
	function automatic res_t host_tick(inout host_state_t s, input cfg_regs_t c,
			input item_t it);
		res_t r;
		logic wdone;
		logic rvalid;
		wdone  = 1'b0;
		rvalid = 1'b0;
		case (s.ph)
			S_IDLE: begin
				if (it.mode == MODE_WRITE) begin
					s.clk_low  = 1'b0;
					s.dat_low  = 1'b0;
					s.shift    = it.tx_byte;
					s.parity   = 1'b1;
					s.nbits    = '0;
					s.wait_cnt = c.inhibit_ticks;
					s.ph       = S_WR_RELEASE;
				end else if (it.mode == MODE_READ) begin
					s.clk_low = 1'b0;
					s.dat_low = 1'b0;
					s.shift   = '0;
					s.nbits   = '0;
					s.ph      = S_RD_FALL;
				end
			end
			S_WR_RELEASE: begin
				if (delay_over(s.wait_cnt)) begin
					s.clk_low  = 1'b1;
					s.wait_cnt = c.inhibit_ticks;
					s.ph       = S_WR_INHIBIT;
				end
			end
			S_WR_INHIBIT: begin
				if (delay_over(s.wait_cnt)) begin
					s.dat_low  = 1'b1;
					s.wait_cnt = c.request_ticks;
					s.ph       = S_WR_RTS;
				end
			end
			S_WR_RTS: begin
				if (delay_over(s.wait_cnt)) begin
					s.clk_low = 1'b0;
					s.ph      = S_WR_START;
				end
			end
			S_WR_START: begin
				if (!it.clk_line) begin
					s.dat_low = ~s.shift[0];
					s.ph      = S_WR_BIT_HI;
				end
			end
			S_WR_BIT_HI: begin
				if (it.clk_line)
					s.ph = S_WR_BIT_LO;
			end
			// next data bit, or odd parity after the eighth
			S_WR_BIT_LO: begin
				if (!it.clk_line) begin
					s.parity = s.parity ^ s.shift[0];
					s.shift  = s.shift >> 1;
					s.nbits  = s.nbits + 1'b1;
					if (s.nbits >= FRAME_BITS) begin
						s.dat_low = ~s.parity;
						s.ph      = S_WR_PAR_HI;
					end else begin
						s.dat_low = ~s.shift[0];
						s.ph      = S_WR_BIT_HI;
					end
				end
			end
			S_WR_PAR_HI: begin
				if (it.clk_line)
					s.ph = S_WR_PAR_LO;
			end
			S_WR_PAR_LO: begin
				if (!it.clk_line) begin
					s.dat_low  = 1'b0;
					s.wait_cnt = c.stop_delay_ticks;
					s.ph       = S_WR_STOP_DLY;
				end
			end
			S_WR_STOP_DLY: begin
				if (delay_over(s.wait_cnt))
					s.ph = S_WR_STOP_LO;
			end
			S_WR_STOP_LO: begin
				if (!it.clk_line)
					s.ph = S_WR_LINES_UP;
			end
			S_WR_LINES_UP: begin
				if (it.clk_line && it.data_line) begin
					s.clk_low = 1'b1;
					wdone     = 1'b1;
					s.ph      = S_IDLE;
				end
			end
			S_RD_FALL: begin
				if (!it.clk_line)
					s.ph = S_RD_START;
			end
			S_RD_START: begin
				if (it.clk_line)
					s.ph = S_RD_BIT_LO;
			end
			S_RD_BIT_LO: begin
				if (!it.clk_line) begin
					if (it.data_line)
						s.shift[s.nbits[2:0]] = 1'b1;
					s.ph = S_RD_BIT_HI;
				end
			end
			S_RD_BIT_HI: begin
				if (it.clk_line) begin
					s.nbits = s.nbits + 1'b1;
					s.ph    = (s.nbits >= FRAME_BITS) ? S_RD_PAR_LO : S_RD_BIT_LO;
				end
			end
			S_RD_PAR_LO: begin
				if (!it.clk_line)
					s.ph = S_RD_PAR_HI;
			end
			S_RD_PAR_HI: begin
				if (it.clk_line)
					s.ph = S_RD_STOP_LO;
			end
			S_RD_STOP_LO: begin
				if (!it.clk_line)
					s.ph = S_RD_STOP_HI;
			end
			S_RD_STOP_HI: begin
				if (it.clk_line) begin
					s.clk_low  = 1'b1;
					s.wait_cnt = c.read_hold_ticks;
					s.ph       = S_RD_HOLD;
				end
			end
			S_RD_HOLD: begin
				if (delay_over(s.wait_cnt)) begin
					s.rx_last = s.shift;
					rvalid    = 1'b1;
					s.ph      = S_IDLE;
				end
			end
			default: begin
				s.ph = S_IDLE;
			end
		endcase
		r.clk_drive_low  = s.clk_low;
		r.data_drive_low = s.dat_low;
		r.busy_res       = (s.ph != S_IDLE);
		r.write_done     = wdone;
		r.rx_valid       = rvalid;
		r.rx_byte        = s.rx_last;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus generation
	// ------------------------------------------------------------------------

	// phases in which the host only counts ticks or sits idle
	function automatic bit line_levels_ignored(host_phase_t ph);
		case (ph)
			S_IDLE, S_WR_RELEASE, S_WR_INHIBIT, S_WR_RTS, S_WR_STOP_DLY, S_RD_HOLD:
				return 1'b1;
			default:
				return 1'b0;
		endcase
	endfunction

	function automatic bit quiet_now();
		return last_leg && tick_queue.size() < 250;
	endfunction

	// one tick request; the device clock runs free while the host waits on edges
	task automatic queue_tick(input logic [MODE_W-1:0] md, input logic [7:0] tx,
			input bit hold);
		item_t it;
		if (dev_half == 0) begin
			dev_clk  = ~dev_clk;
			dev_half = $urandom_range(0, 3);
		end else begin
			dev_half--;
		end
		it.mode     = md;
		it.tx_byte  = tx;
		it.clk_line = line_levels_ignored(gen_host.ph) ? 1'($urandom_range(0, 1)) : dev_clk;
		it.data_line = (gen_host.ph == S_RD_BIT_LO) ? dev_byte[gen_host.nbits[2:0]]
			: 1'($urandom_range(0, 1));
		void'(host_tick(gen_host, gen_cfg, it));
		tick_queue.push_back('{it: it, wait_drain: hold});
		gen_count++;
	endtask

	// a command followed by ticks until the host is idle again
	task automatic run_cmd(input logic [MODE_W-1:0] md, input logic [7:0] tx,
			input logic [7:0] rx_pattern, input bit busy_noise, input bit hold);
		logic [MODE_W-1:0] m;
		dev_byte = rx_pattern;
		queue_tick(md, tx, hold);
		while (gen_host.ph != S_IDLE) begin
			// stray commands while busy must be ignored
			m = (busy_noise && $urandom_range(0, 15) == 0) ? 2'($urandom_range(1, 3))
				: MODE_TICK;
			queue_tick(m, 8'($urandom), 1'b0);
		end
		repeat ($urandom_range(0, 3))
			queue_tick(MODE_TICK, 8'($urandom), 1'b0);
	endtask

	task automatic run_random(input int n_items);
		int start;
		int pick;
		logic [MODE_W-1:0] m;
		start = gen_count;
		while (gen_count - start < n_items) begin
			pick = $urandom_range(0, 9);
			m = (pick < 4) ? MODE_WRITE : (pick < 8) ? MODE_READ
				: (pick == 8) ? MODE_SPARE : MODE_TICK;
			run_cmd(m, 8'($urandom), 8'($urandom), $urandom_range(0, 3) == 0, 1'b0);
		end
	endtask

	// ------------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------------

	task automatic reg_access(input logic [1:0] idx, input logic [TICK_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_INHIBIT:   chk_cfg.inhibit_ticks    = val;
			REG_REQUEST:   chk_cfg.request_ticks    = val;
			REG_STOP_DLY:  chk_cfg.stop_delay_ticks = val;
			REG_READ_HOLD: chk_cfg.read_hold_ticks  = val;
			default: ;
		endcase
		// read back through the same address
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[TICK_W-1:0] !== val) begin
			$error("register %0d readback: expected %0d, got %0d", idx, val,
				prdata[TICK_W-1:0]);
			n_err++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_regs(input logic [TICK_W-1:0] inh, input logic [TICK_W-1:0] rts,
			input logic [TICK_W-1:0] stp, input logic [TICK_W-1:0] hld);
		gen_cfg = '{inhibit_ticks: inh, request_ticks: rts, stop_delay_ticks: stp,
			read_hold_ticks: hld};
		reg_access(REG_INHIBIT, inh);
		reg_access(REG_REQUEST, rts);
		reg_access(REG_STOP_DLY, stp);
		reg_access(REG_READ_HOLD, hld);
	endtask

	// wait until every request has gone through and its result has come back
	task automatic wait_drained();
		while (tick_queue.size() != 0 || have_cur || want_status.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(input string nm, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", nm, exp_v, act_v);
			n_err++;
		end
	endtask

	// ------------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// request driver
	// ------------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n) begin
			// retire the request taken at the last rising edge
			if (cmd_taken)
				have_cur = 1'b0;
			if (!have_cur) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (tick_queue.size() != 0
						&& !(tick_queue[0].wait_drain && want_status.size() != 0)) begin
					cur      = tick_queue.pop_front();
					have_cur = 1'b1;
					if (!quiet_now() && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 4);
				end
			end
			cmd_ch.valid     <= have_cur;
			cmd_ch.mode      <= cur.it.mode;
			cmd_ch.tx_byte   <= cur.it.tx_byte;
			cmd_ch.clk_line  <= cur.it.clk_line;
			cmd_ch.data_line <= cur.it.data_line;
		end
	end

	// ------------------------------------------------------------------------
	// status receiver, with one long hold-off to back the core up
	// ------------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && n_taken >= 300) begin
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (!quiet_now() && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 3);
				rdy        = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			sts_ch.ready <= rdy;
		end
	end

	// ------------------------------------------------------------------------
	// monitor: results against predictions, then newly taken requests
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (sts_ch.valid && sts_ch.ready) begin
				if (want_status.size() == 0) begin
					$error("status result with no request outstanding");
					n_err++;
				end else begin
					got_want = want_status.pop_front();
					check_field("clk_drive_low", got_want.clk_drive_low, sts_ch.clk_drive_low);
					check_field("data_drive_low", got_want.data_drive_low,
						sts_ch.data_drive_low);
					check_field("busy_res", got_want.busy_res, sts_ch.busy_res);
					check_field("write_done", got_want.write_done, sts_ch.write_done);
					check_field("rx_valid", got_want.rx_valid, sts_ch.rx_valid);
					check_field("rx_byte", got_want.rx_byte, sts_ch.rx_byte);
				end
			end
			cmd_taken = cmd_ch.valid && cmd_ch.ready;
			if (cmd_taken) begin
				took_item.mode      = cmd_ch.mode;
				took_item.tx_byte   = cmd_ch.tx_byte;
				took_item.clk_line  = cmd_ch.clk_line;
				took_item.data_line = cmd_ch.data_line;
				want_status.push_back(host_tick(chk_host, chk_cfg, took_item));
				n_taken++;
			end
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// sequence of phases
	// ------------------------------------------------------------------------

	initial begin
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.mode      = MODE_TICK;
		cmd_ch.tx_byte   = '0;
		cmd_ch.clk_line  = 1'b1;
		cmd_ch.data_line = 1'b1;
		sts_ch.ready     = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		gen_host         = host_reset_state();
		chk_host         = host_reset_state();
		gen_cfg          = '{inhibit_ticks: INHIBIT_RST, request_ticks: REQUEST_RST,
			stop_delay_ticks: STOP_DLY_RST, read_hold_ticks: READ_HOLD_RST};
		chk_cfg          = gen_cfg;
		dev_clk          = 1'b1;
		dev_half         = 0;
		dev_byte         = '0;
		gen_count        = 0;
		last_leg         = 1'b0;
		n_err            = 0;
		n_taken          = 0;
		cycles           = 0;
		cmd_taken        = 1'b0;
		have_cur         = 1'b0;
		send_gap         = 0;
		stall_left       = 0;
		hold_left        = 0;
		long_hold_done   = 1'b0;
		cur.it           = '0;
		cur.wait_drain   = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset delays: spare mode code in idle, then one read
		run_cmd(MODE_SPARE, 8'hFF, 8'h00, 1'b0, 1'b0);
		run_cmd(MODE_READ, 8'h00, 8'h81, 1'b0, 1'b0);
		wait_drained();

		// zero delays: byte extremes both ways, stray commands while busy
		load_regs('0, '0, '0, '0);
		run_cmd(MODE_WRITE, 8'h00, 8'h00, 1'b0, 1'b0);
		run_cmd(MODE_WRITE, 8'hFF, 8'h00, 1'b0, 1'b0);
		run_cmd(MODE_READ, 8'h00, 8'h00, 1'b0, 1'b0);
		run_cmd(MODE_READ, 8'h00, 8'hFF, 1'b0, 1'b0);
		run_cmd(MODE_WRITE, 8'hA5, 8'h00, 1'b1, 1'b0);
		run_cmd(MODE_READ, 8'h00, 8'h5A, 1'b1, 1'b0);
		run_cmd(MODE_TICK, 8'h00, 8'h00, 1'b0, 1'b0);
		wait_drained();

		// short delays, random traffic with one full drain in the middle
		load_regs(10'($urandom_range(1, 6)), 10'($urandom_range(1, 6)),
			10'($urandom_range(1, 6)), 10'($urandom_range(1, 6)));
		run_random(230);
		run_cmd(MODE_READ, 8'($urandom), 8'($urandom), 1'b0, 1'b1);
		run_random(230);
		wait_drained();

		// random small delays, no idling towards the end
		load_regs(10'($urandom_range(0, 7)), 10'($urandom_range(0, 7)),
			10'($urandom_range(0, 7)), 10'($urandom_range(0, 7)));
		last_leg = 1'b1;
		run_random(230);
		wait_drained();

		repeat (8) @(posedge clk);
		if (n_err == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/ps2hbt_pkg.sv
rtl/core/ps2hbt_if.sv
rtl/core/ps2hbt_cfg.sv
rtl/core/ps2hbt_fsm.sv
rtl/core/ps2_host_byte_transceiver_core.sv
sim/ps2_host_byte_transceiver_core_tb.sv
